[hdl/frr_pkg.sv]
`timescale 1ns / 1ps

package frr_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_WIDTH-1:0]   count_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] numerator_in;
    logic signed [VALUE_WIDTH-1:0] denominator_in;
  } frr_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] numerator_out;
    logic signed [VALUE_WIDTH-1:0] denominator_out;
    logic                          zero_denominator;
  } frr_out_t;

  // result handed back by an iterative unit
  typedef struct packed {
    logic   done;
    value_t value;
  } frr_res_t;

  localparam count_t LAST_STEP = count_t'(VALUE_WIDTH - 1);

endpackage

[hdl/frr_gcd.sv]
`timescale 1ns / 1ps

module frr_gcd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  frr_pkg::value_t a_i,
  input  frr_pkg::value_t b_i,
  output frr_pkg::frr_res_t res_o
);
  import frr_pkg::*;

  value_t a_q, a_d;
  value_t b_q, b_d;
  count_t k_q, k_d;
  logic   busy_q;
  logic   done_q;
  value_t g_q;

  // one binary gcd step: halve an even operand or subtract and halve
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + count_t'(1);
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q > b_q) begin
      a_d = (a_q - b_q) >> 1;
    end else begin
      b_d = (b_q - a_q) >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (a_q == b_q)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (a_q == b_q) begin
        g_q <= a_q << k_q;
      end else begin
        a_q <= a_d;
        b_q <= b_d;
        k_q <= k_d;
      end
    end
  end

  assign res_o.done  = done_q;
  assign res_o.value = g_q;

endmodule

[hdl/frr_div.sv]
`timescale 1ns / 1ps

module frr_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  frr_pkg::value_t dividend_i,
  input  frr_pkg::value_t divisor_i,
  output frr_pkg::frr_res_t res_o
);
  import frr_pkg::*;

  value_t rem_q;
  value_t dvd_q;
  count_t cnt_q;
  logic   busy_q;
  logic   done_q;
  value_t rem_sh;
  logic   fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q[VALUE_WIDTH-2:0], dvd_q[VALUE_WIDTH-1]};
  assign fits   = (rem_sh >= divisor_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + count_t'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - divisor_i) : rem_sh;
      dvd_q <= {dvd_q[VALUE_WIDTH-2:0], fits};
    end
  end

  assign res_o.done  = done_q;
  assign res_o.value = dvd_q;

endmodule

[hdl/fraction_reducer.sv]
`timescale 1ns / 1ps
// flow: a zero numerator or denominator goes straight to the output register; otherwise the binary
// gcd loop runs, then the shared divider divides the numerator and then the denominator by the gcd
// throughput: one item at a time, the next item is taken in the cycle the result can first be
// taken; the gcd loop and the shared divider, used twice per item, set how long an item takes
// reset: asynchronous, active low; clears the sequencer and the output valid
module fraction_reducer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  frr_pkg::frr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output frr_pkg::frr_out_t out_data_o
);
  import frr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV_NUM,
    S_DIV_DEN,
    S_FINISH
  } state_e;

  state_e   state_q;
  logic     gcd_start_q;
  logic     div_start_q;
  logic     out_valid_q;
  frr_out_t out_q;
  value_t   num_mag_q;
  value_t   den_mag_q;
  logic     den_neg_q;
  value_t   g_q;
  value_t   dvd_q;
  value_t   res_num_q;
  value_t   res_den_q;
  logic     res_zero_q;

  value_t   in_num;
  value_t   in_den;
  logic     num_neg;
  logic     den_neg;
  value_t   num_mag;
  value_t   den_mag;
  frr_res_t gcd_res;
  frr_res_t div_res;

  assign in_num  = value_t'(in_data_i.numerator_in);
  assign in_den  = value_t'(in_data_i.denominator_in);
  assign num_neg = in_num[VALUE_WIDTH-1];
  assign den_neg = in_den[VALUE_WIDTH-1];
  assign num_mag = num_neg ? (value_t'(0) - in_num) : in_num;
  assign den_mag = den_neg ? (value_t'(0) - in_den) : in_den;

  frr_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gcd_start_q),
    .a_i    (num_mag_q),
    .b_i    (den_mag_q),
    .res_o  (gcd_res)
  );

  frr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(dvd_q),
    .divisor_i (g_q),
    .res_o     (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gcd_start_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      gcd_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (den_mag == '0) begin
              state_q <= S_FINISH;
            end else if (num_mag == '0) begin
              state_q <= S_FINISH;
            end else begin
              gcd_start_q <= 1'b1;
              state_q     <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (gcd_res.done) begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV_NUM;
          end
        end
        S_DIV_NUM: begin
          if (div_res.done) begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV_DEN;
          end
        end
        S_DIV_DEN: begin
          if (div_res.done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        num_mag_q  <= num_mag;
        den_mag_q  <= den_mag;
        den_neg_q  <= den_neg ^ num_neg;
        res_num_q  <= '0;
        res_den_q  <= value_t'(1);
        res_zero_q <= (den_mag == '0);
      end
      S_GCD: begin
        if (gcd_res.done) begin
          g_q   <= gcd_res.value;
          dvd_q <= num_mag_q;
        end
      end
      S_DIV_NUM: begin
        if (div_res.done) begin
          res_num_q <= div_res.value;
          dvd_q     <= den_mag_q;
        end
      end
      S_DIV_DEN: begin
        if (div_res.done) begin
          res_den_q <= den_neg_q ? (value_t'(0) - div_res.value) : div_res.value;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q.numerator_out    <= res_num_q;
          out_q.denominator_out  <= res_den_q;
          out_q.zero_denominator <= res_zero_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[test/tb_fraction_reducer.sv]
`timescale 1ns / 1ps

module tb_fraction_reducer;
  import frr_pkg::*;

  localparam int     ITEMS_PER_PHASE = 250;
  localparam int     HOLD_CYCLES     = 400;
  localparam int     WATCHDOG_LIMIT  = 5000;
  localparam int     DRAIN_CYCLES    = 4 * VALUE_WIDTH + 10;
  localparam value_t MAX_POS         = 32'h7FFF_FFFF;
  localparam value_t MAX_NEG         = 32'h8000_0001;
  localparam value_t MOST_NEG        = 32'h8000_0000;

  typedef struct {
    value_t num;
    value_t den;
    bit     typed;
    value_t want_num;
    value_t want_den;
    bit     want_zd;
  } directed_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  frr_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  frr_out_t out_data_o;

  frr_out_t reduced_q[$];
  int       error_count     = 0;
  int       fractions_sent;
  int       results_checked = 0;
  int       zero_den_seen   = 0;
  int       idle_cycles     = 0;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_pending    = 1'b0;
  bit       hold_done;
  int       hold_cycles_left;

  int send_idle_pcts[4]  = '{0, 67, 0, 8};
  int recv_stall_pcts[4] = '{0, 0, 67, 8};

  directed_row_t directed_rows[25] = '{
    '{32'd0,    32'd0,    1'b1, 32'd0,   32'd1,   1'b1},
    '{32'd5,    32'd0,    1'b1, 32'd0,   32'd1,   1'b1},
    '{-32'd7,   32'd0,    1'b1, 32'd0,   32'd1,   1'b1},
    '{MAX_POS,  32'd0,    1'b1, 32'd0,   32'd1,   1'b1},
    '{32'd0,    32'd5,    1'b1, 32'd0,   32'd1,   1'b0},
    '{32'd0,    -32'd3,   1'b1, 32'd0,   32'd1,   1'b0},
    '{32'd6,    32'd6,    1'b1, 32'd1,   32'd1,   1'b0},
    '{-32'd6,   32'd6,    1'b1, 32'd1,   -32'd1,  1'b0},
    '{32'd6,    -32'd6,   1'b1, 32'd1,   -32'd1,  1'b0},
    '{-32'd6,   -32'd6,   1'b1, 32'd1,   32'd1,   1'b0},
    '{MAX_POS,  MAX_POS,  1'b1, 32'd1,   32'd1,   1'b0},
    '{MAX_NEG,  MAX_POS,  1'b1, 32'd1,   -32'd1,  1'b0},
    '{MAX_POS,  32'd1,    1'b1, MAX_POS, 32'd1,   1'b0},
    '{32'd1,    MAX_POS,  1'b1, 32'd1,   MAX_POS, 1'b0},
    '{MAX_NEG,  -32'd1,   1'b1, MAX_POS, 32'd1,   1'b0},
    '{32'd12,   32'd18,   1'b0, 32'd0,   32'd0,   1'b0},
    '{-32'd12,  32'd18,   1'b0, 32'd0,   32'd0,   1'b0},
    '{32'd100,  -32'd75,  1'b0, 32'd0,   32'd0,   1'b0},
    '{32'd2147483646, 32'd1073741823, 1'b0, 32'd0, 32'd0, 1'b0},
    '{MOST_NEG, 32'd2,    1'b0, 32'd0,   32'd0,   1'b0},
    '{MOST_NEG, 32'd1,    1'b0, 32'd0,   32'd0,   1'b0},
    '{32'd1,    MOST_NEG, 1'b0, 32'd0,   32'd0,   1'b0},
    '{-32'd1,   MOST_NEG, 1'b0, 32'd0,   32'd0,   1'b0},
    '{MOST_NEG, MOST_NEG, 1'b0, 32'd0,   32'd0,   1'b0},
    '{32'd7,    32'd13,   1'b0, 32'd0,   32'd0,   1'b0}
  };

  fraction_reducer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic frr_out_t reduce_fraction(input frr_in_t fraction);
    logic     num_neg;
    logic     den_neg;
    value_t   num_mag;
    value_t   den_mag;
    value_t   a;
    value_t   b;
    value_t   t;
    frr_out_t res;
    num_neg = fraction.numerator_in[VALUE_WIDTH-1];
    den_neg = fraction.denominator_in[VALUE_WIDTH-1];
    num_mag = num_neg ? ~value_t'(fraction.numerator_in) + 1'b1 : value_t'(fraction.numerator_in);
    den_mag = den_neg ? ~value_t'(fraction.denominator_in) + 1'b1
                      : value_t'(fraction.denominator_in);
    res = '0;
    res.denominator_out = 1;
    if (den_mag == 0) begin
      res.zero_denominator = 1'b1;
    end else if (num_mag != 0) begin
      if (num_neg) begin
        den_neg = ~den_neg;
      end
      a = num_mag;
      b = den_mag;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      num_mag = num_mag / a;
      den_mag = den_mag / a;
      res.numerator_out   = num_mag;
      res.denominator_out = den_neg ? ~den_mag + 1'b1 : den_mag;
    end
    return res;
  endfunction

  function automatic frr_in_t make_fraction();
    int unsigned kind;
    int unsigned common;
    int unsigned num_mag;
    int unsigned den_mag;
    frr_in_t     fraction;
    kind   = $urandom_range(99);
    common = $urandom_range(65535, 1);
    if (kind < 15) begin
      num_mag = $urandom_range(32'h7FFF_FFFF, 0);
      den_mag = $urandom_range(32'h7FFF_FFFF, 0);
    end else if (kind < 30) begin
      num_mag = $urandom_range(1000);
      den_mag = $urandom_range(1000);
    end else if (kind < 70) begin
      num_mag = $urandom_range(32767, 1) * common;
      den_mag = $urandom_range(32767, 1) * common;
    end else if (kind < 80) begin
      num_mag = $urandom_range(32'h7FFF_FFFF, 1);
      den_mag = num_mag;
    end else if (kind < 88) begin
      num_mag = $urandom_range(32'h7FFF_FFFF, 0);
      den_mag = 0;
    end else if (kind < 95) begin
      num_mag = 0;
      den_mag = $urandom_range(32'h7FFF_FFFF, 1);
    end else begin
      num_mag = 32'd1 << $urandom_range(30);
      den_mag = 32'd1 << $urandom_range(30);
    end
    fraction.numerator_in   = $urandom_range(1) ? -num_mag : num_mag;
    fraction.denominator_in = $urandom_range(1) ? -den_mag : den_mag;
    return fraction;
  endfunction

  task automatic offer_fraction(input frr_in_t fraction, input frr_out_t reduced);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= fraction;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reduced_q.push_back(reduced);
    fractions_sent++;
  endtask

  // receiver, with one long hold-off on request
  initial begin
    out_stall_i      = 1'b0;
    hold_cycles_left = 0;
    hold_done        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending && !hold_done) begin
        hold_cycles_left = HOLD_CYCLES;
        hold_done        = 1'b1;
      end
      if (hold_cycles_left != 0) begin
        hold_cycles_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    frr_out_t got;
    frr_out_t want;
    if (out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (reduced_q.size() == 0) begin
        $error("result with no item outstanding: %0d / %0d, zero_denominator %0d",
               got.numerator_out, got.denominator_out, got.zero_denominator);
        error_count++;
      end else begin
        want = reduced_q.pop_front();
        results_checked++;
        if (got.zero_denominator) zero_den_seen++;
        if (got.numerator_out !== want.numerator_out) begin
          $error("numerator_out: expected %0d, got %0d",
                 want.numerator_out, got.numerator_out);
          error_count++;
        end
        if (got.denominator_out !== want.denominator_out) begin
          $error("denominator_out: expected %0d, got %0d",
                 want.denominator_out, got.denominator_out);
          error_count++;
        end
        if (got.zero_denominator !== want.zero_denominator) begin
          $error("zero_denominator: expected %0d, got %0d",
                 want.zero_denominator, got.zero_denominator);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    frr_in_t  fraction;
    frr_out_t want;
    fractions_sent  = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 25; i++) begin
      fraction.numerator_in   = directed_rows[i].num;
      fraction.denominator_in = directed_rows[i].den;
      if (directed_rows[i].typed) begin
        want.numerator_out    = directed_rows[i].want_num;
        want.denominator_out  = directed_rows[i].want_den;
        want.zero_denominator = directed_rows[i].want_zd;
      end else begin
        want = reduce_fraction(fraction);
      end
      offer_fraction(fraction, want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_idle_pcts[phase];
      recv_stall_pct = recv_stall_pcts[phase];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // fill the block while the receiver holds off
        if (phase == 0 && n == 40) hold_pending = 1'b1;
        fraction = make_fraction();
        offer_fraction(fraction, reduce_fraction(fraction));
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d fractions offered, %0d results checked (%0d with a zero denominator)",
             fractions_sent, results_checked, zero_den_seen);
    $display("covered extremes, sign flips, equal magnitudes and four idle/stall mixes");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
